@@ src/ttnv_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttnv_pkg: shared types and constants
// Item codes, queue sizing, register indexes and the status bundle that the
// table search units hand to the back end.
// ----------------------------------------------------------------------------
package ttnv_pkg;

  // Fixed field widths of the item and the configuration registers.
  localparam int MODE_BITS = 2;
  localparam int SLOT_BITS = 10;
  localparam int REG_BITS  = 11;
  localparam int CFG_IDX_BITS = 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] CFG_COUNT_A = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_COUNT_B = 1'b1;

  // Queue between the front and the back end.
  localparam int Q_DEPTH    = 2;
  localparam int Q_PTR_BITS = $clog2(Q_DEPTH);
  localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

  // Item kinds; the encoding matches the mode field.
  typedef enum logic [MODE_BITS-1:0] {
    OP_LOAD_A = 2'd0,
    OP_LOAD_B = 2'd1,
    OP_QUERY  = 2'd2
  } ttnv_op_t;

  // Search unit sequencer.
  typedef enum logic [2:0] {
    SR_IDLE,
    SR_STEP,
    SR_GET_HI,
    SR_GET_LO,
    SR_DONE
  } ttnv_sr_state_t;

  // Back end sequencer.
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SEARCH,
    BK_DIST,
    BK_SUM,
    BK_MIN,
    BK_OUT
  } ttnv_bk_state_t;

  // Status of one search unit: finished, and which neighbors exist.
  typedef struct packed {
    logic done;
    logic has_hi;
    logic has_lo;
  } ttnv_srch_stat_t;

endpackage

@@ src/ttnv_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttnv_front: input stage
// Registers each incoming item, drops items that have no effect and packs the
// rest for the queue.
// ----------------------------------------------------------------------------
module ttnv_front #(
  parameter int TABLE_DEPTH = 1024,
  parameter int POS_BITS    = 40
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [ttnv_pkg::MODE_BITS-1:0]        in_mode,
  input  logic [ttnv_pkg::SLOT_BITS-1:0]        in_slot,
  input  logic [POS_BITS-1:0]                   in_position,
  output logic                                  push_valid,
  input  logic                                  push_ready,
  output logic [ttnv_pkg::MODE_BITS+ttnv_pkg::SLOT_BITS+POS_BITS-1:0] push_data
);
  import ttnv_pkg::*;

  logic                 fr_valid_r;
  ttnv_op_t             fr_op_r;
  logic [SLOT_BITS-1:0] fr_slot_r;
  logic [POS_BITS-1:0]  fr_pos_r;
  logic                 accept;
  logic                 keep;
  logic                 slot_ok;

  assign in_stall = fr_valid_r && !push_ready;
  assign accept   = in_valid && !in_stall;
  assign slot_ok  = 32'(in_slot) < TABLE_DEPTH;

  // Loads beyond the table and the unused mode leave no trace.
  always_comb begin
    case (in_mode)
      OP_LOAD_A, OP_LOAD_B: keep = slot_ok;
      OP_QUERY:             keep = 1'b1;
      default:              keep = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else if (accept) begin
      fr_valid_r <= keep;
    end else if (push_ready) begin
      fr_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fr_op_r   <= ttnv_op_t'(in_mode);
      fr_slot_r <= in_slot;
      fr_pos_r  <= in_position;
    end
  end

  assign push_valid = fr_valid_r;
  assign push_data  = {fr_op_r, fr_slot_r, fr_pos_r};

endmodule

@@ src/ttnv_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttnv_queue: short item queue
// A small register FIFO that lets the front and the back end stall apart.
// ----------------------------------------------------------------------------
module ttnv_queue #(
  parameter int W = 52
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);
  import ttnv_pkg::*;

  logic [W-1:0]          entry_r [Q_DEPTH];
  logic [Q_PTR_BITS-1:0] wr_ptr_r;
  logic [Q_PTR_BITS-1:0] rd_ptr_r;
  logic [Q_CNT_BITS-1:0] cnt_r;
  logic                  do_push;
  logic                  do_pop;

  assign push_ready = cnt_r != Q_CNT_BITS'(Q_DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_data   = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == Q_PTR_BITS'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == Q_PTR_BITS'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ src/ttnv_search.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttnv_search: table memory and binary search
// Holds one sorted table and finds the first entry at or above a position,
// then fetches that entry and the one below it.
// ----------------------------------------------------------------------------
module ttnv_search #(
  parameter int TABLE_DEPTH = 1024,
  parameter int POS_BITS    = 40
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              wr_en,
  input  logic [$clog2(TABLE_DEPTH)-1:0]    wr_addr,
  input  logic [POS_BITS-1:0]               wr_data,
  input  logic                              start,
  input  logic [ttnv_pkg::REG_BITS-1:0]     count,
  input  logic [POS_BITS-1:0]               x,
  output ttnv_pkg::ttnv_srch_stat_t         stat,
  output logic [POS_BITS-1:0]               cand_hi,
  output logic [POS_BITS-1:0]               cand_lo
);
  import ttnv_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic [POS_BITS-1:0] table_mem [TABLE_DEPTH];

  ttnv_sr_state_t      state_r, state_nxt;
  logic [CW-1:0]       lo_r, lo_nxt;
  logic [CW-1:0]       hi_r, hi_nxt;
  logic [CW-1:0]       n_r, n_nxt;
  logic [AW-1:0]       mid_r, mid_nxt;
  logic [POS_BITS-1:0] x_r, x_nxt;
  logic [POS_BITS-1:0] rdata_r;
  logic [POS_BITS-1:0] cand_hi_r, cand_hi_nxt;
  logic [POS_BITS-1:0] cand_lo_r, cand_lo_nxt;
  logic                has_hi_r, has_hi_nxt;
  logic                has_lo_r, has_lo_nxt;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;

  logic [CW-1:0]       n_cl;
  logic [CW:0]         sum0;
  logic [CW-1:0]       lo_s, hi_s, lo_s_dec, lo_r_dec;
  logic [CW:0]         sum_s;
  logic                go_up;

  // A count of zero acts as one, a count beyond the table as the full table.
  always_comb begin
    if (count == '0) begin
      n_cl = CW'(1);
    end else if (32'(count) > TABLE_DEPTH) begin
      n_cl = CW'(TABLE_DEPTH);
    end else begin
      n_cl = CW'(count);
    end
  end

  assign sum0      = {1'b0, n_cl};

  // One probe resolves per cycle: the entry read last cycle narrows the range.
  assign go_up    = rdata_r < x_r;
  assign lo_s     = go_up ? CW'(mid_r) + CW'(1) : lo_r;
  assign hi_s     = go_up ? hi_r : CW'(mid_r);
  assign sum_s    = {1'b0, lo_s} + {1'b0, hi_s};
  assign lo_s_dec = lo_s - CW'(1);
  assign lo_r_dec = lo_r - CW'(1);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      SR_IDLE, SR_DONE: begin
        if (start) state_nxt = SR_STEP;
      end
      SR_STEP: begin
        if (lo_s < hi_s) begin
          state_nxt = SR_STEP;
        end else if (lo_s < n_r) begin
          state_nxt = SR_GET_HI;
        end else begin
          state_nxt = SR_GET_LO;
        end
      end
      SR_GET_HI: state_nxt = has_lo_r ? SR_GET_LO : SR_DONE;
      SR_GET_LO: state_nxt = SR_DONE;
      default:   state_nxt = SR_IDLE;
    endcase
  end

  always_comb begin
    lo_nxt      = lo_r;
    hi_nxt      = hi_r;
    n_nxt       = n_r;
    mid_nxt     = mid_r;
    x_nxt       = x_r;
    cand_hi_nxt = cand_hi_r;
    cand_lo_nxt = cand_lo_r;
    has_hi_nxt  = has_hi_r;
    has_lo_nxt  = has_lo_r;
    rd_en       = 1'b0;
    rd_addr     = mid_r;
    case (state_r)
      SR_IDLE, SR_DONE: begin
        if (start) begin
          lo_nxt  = '0;
          hi_nxt  = n_cl;
          n_nxt   = n_cl;
          x_nxt   = x;
          mid_nxt = sum0[AW:1];
          rd_en   = 1'b1;
          rd_addr = sum0[AW:1];
        end
      end
      SR_STEP: begin
        lo_nxt = lo_s;
        hi_nxt = hi_s;
        rd_en  = 1'b1;
        if (lo_s < hi_s) begin
          mid_nxt = sum_s[AW:1];
          rd_addr = sum_s[AW:1];
        end else if (lo_s < n_r) begin
          rd_addr    = lo_s[AW-1:0];
          has_hi_nxt = 1'b1;
          has_lo_nxt = lo_s != '0;
        end else begin
          rd_addr    = lo_s_dec[AW-1:0];
          has_hi_nxt = 1'b0;
          has_lo_nxt = 1'b1;
        end
      end
      SR_GET_HI: begin
        cand_hi_nxt = rdata_r;
        if (has_lo_r) begin
          rd_en   = 1'b1;
          rd_addr = lo_r_dec[AW-1:0];
        end
      end
      SR_GET_LO: begin
        cand_lo_nxt = rdata_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SR_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    n_r       <= n_nxt;
    mid_r     <= mid_nxt;
    x_r       <= x_nxt;
    cand_hi_r <= cand_hi_nxt;
    cand_lo_r <= cand_lo_nxt;
    has_hi_r  <= has_hi_nxt;
    has_lo_r  <= has_lo_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= table_mem[rd_addr];
    end
  end

  assign stat.done   = state_r == SR_DONE;
  assign stat.has_hi = has_hi_r;
  assign stat.has_lo = has_lo_r;
  assign cand_hi     = cand_hi_r;
  assign cand_lo     = cand_lo_r;

endmodule

@@ src/ttnv_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttnv_back: item execution
// Writes loads into the tables, runs both searches for a query, combines the
// candidates into the least cost and holds the result for the output.
// ----------------------------------------------------------------------------
module ttnv_back #(
  parameter int TABLE_DEPTH = 1024,
  parameter int POS_BITS    = 40
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  pop_valid,
  output logic                                  pop_ready,
  input  logic [ttnv_pkg::MODE_BITS+ttnv_pkg::SLOT_BITS+POS_BITS-1:0] pop_data,
  input  logic [ttnv_pkg::REG_BITS-1:0]         count_a,
  input  logic [ttnv_pkg::REG_BITS-1:0]         count_b,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [POS_BITS:0]                     out_cost
);
  import ttnv_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);

  ttnv_bk_state_t       state_r, state_nxt;
  ttnv_op_t             q_op;
  logic [SLOT_BITS-1:0] q_slot;
  logic [POS_BITS-1:0]  q_pos;
  logic [POS_BITS-1:0]  x_r;

  logic                 wr_a, wr_b, start, ld_out;
  ttnv_srch_stat_t      stat_a, stat_b;
  logic [POS_BITS-1:0]  a_hi, a_lo, b_hi, b_lo;

  logic [POS_BITS-1:0]  ca [2];
  logic [POS_BITS-1:0]  cb [2];
  logic                 ha [2];
  logic                 hb [2];
  logic [POS_BITS-1:0]  da_r  [2];
  logic [POS_BITS-1:0]  db_r  [2];
  logic [POS_BITS-1:0]  dab_r [4];
  logic                 pv_r  [4];
  logic [POS_BITS:0]    c_r   [4];
  logic [POS_BITS:0]    m01, m23;
  logic [POS_BITS:0]    res_r;
  logic                 out_valid_r;
  logic [POS_BITS:0]    out_cost_r;

  function automatic logic [POS_BITS-1:0] absdiff(input logic [POS_BITS-1:0] p,
                                                  input logic [POS_BITS-1:0] q);
    return (p >= q) ? p - q : q - p;
  endfunction

  assign q_op   = ttnv_op_t'(pop_data[POS_BITS+SLOT_BITS +: MODE_BITS]);
  assign q_slot = pop_data[POS_BITS +: SLOT_BITS];
  assign q_pos  = pop_data[POS_BITS-1:0];

  ttnv_search #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .POS_BITS    (POS_BITS)
  ) u_search_a (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_a),
    .wr_addr (AW'(q_slot)),
    .wr_data (q_pos),
    .start   (start),
    .count   (count_a),
    .x       (q_pos),
    .stat    (stat_a),
    .cand_hi (a_hi),
    .cand_lo (a_lo)
  );

  ttnv_search #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .POS_BITS    (POS_BITS)
  ) u_search_b (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_b),
    .wr_addr (AW'(q_slot)),
    .wr_data (q_pos),
    .start   (start),
    .count   (count_b),
    .x       (q_pos),
    .stat    (stat_b),
    .cand_hi (b_hi),
    .cand_lo (b_lo)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (pop_valid && (q_op == OP_QUERY)) state_nxt = BK_SEARCH;
      end
      BK_SEARCH: begin
        if (stat_a.done && stat_b.done) state_nxt = BK_DIST;
      end
      BK_DIST: state_nxt = BK_SUM;
      BK_SUM:  state_nxt = BK_MIN;
      BK_MIN:  state_nxt = BK_OUT;
      BK_OUT: begin
        if (!out_valid_r || !out_stall) state_nxt = BK_IDLE;
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    pop_ready = 1'b0;
    wr_a      = 1'b0;
    wr_b      = 1'b0;
    start     = 1'b0;
    ld_out    = 1'b0;
    case (state_r)
      BK_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          case (q_op)
            OP_LOAD_A: wr_a  = 1'b1;
            OP_LOAD_B: wr_b  = 1'b1;
            OP_QUERY:  start = 1'b1;
            default: ;
          endcase
        end
      end
      BK_OUT: ld_out = !out_valid_r || !out_stall;
      default: ;
    endcase
  end

  // Candidate order: index 0 is the entry at or above x, index 1 the one below.
  always_comb begin
    ca[0] = a_hi;
    ca[1] = a_lo;
    cb[0] = b_hi;
    cb[1] = b_lo;
    ha[0] = stat_a.has_hi;
    ha[1] = stat_a.has_lo;
    hb[0] = stat_b.has_hi;
    hb[1] = stat_b.has_lo;
  end

  assign m01 = (c_r[0] < c_r[1]) ? c_r[0] : c_r[1];
  assign m23 = (c_r[2] < c_r[3]) ? c_r[2] : c_r[3];

  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= q_pos;
    end
    if (state_r == BK_DIST) begin
      for (int i = 0; i < 2; i++) begin
        da_r[i] <= absdiff(x_r, ca[i]);
        db_r[i] <= absdiff(x_r, cb[i]);
        for (int j = 0; j < 2; j++) begin
          dab_r[i*2+j] <= absdiff(ca[i], cb[j]);
          pv_r[i*2+j]  <= ha[i] && hb[j];
        end
      end
    end
    if (state_r == BK_SUM) begin
      for (int i = 0; i < 2; i++) begin
        for (int j = 0; j < 2; j++) begin
          if (pv_r[i*2+j]) begin
            c_r[i*2+j] <= {1'b0, (da_r[i] < db_r[j]) ? da_r[i] : db_r[j]}
                          + {1'b0, dab_r[i*2+j]};
          end else begin
            c_r[i*2+j] <= '1;
          end
        end
      end
    end
    if (state_r == BK_MIN) begin
      res_r <= (m01 < m23) ? m01 : m23;
    end
    if (ld_out) begin
      out_cost_r <= res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ld_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_cost  = out_cost_r;

endmodule

@@ src/two_table_nearest_visit_cost.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_table_nearest_visit_cost: least travel to one A point and one B point
// Two sorted position tables, loaded entry by entry, answer position queries
// with the shortest trip that visits one point of each table.
// ----------------------------------------------------------------------------
// A load item (mode 0 for table A, 1 for table B) writes one entry and gives
// no result; the back end writes it without leaving its idle state. A query
// item (mode 2) gives one cost. Each table lives in its own memory with its
// own search unit, and the two binary searches run side by side: every cycle
// one probe read comes back and picks the next probe; once the range is closed
// the neighbor entries are fetched. The back end then forms the distances,
// the pair sums and the final minimum and loads the output register. Items
// are taken one at a time in the back end; the input register and a
// two-entry queue in front of it keep accepting items while a query is in
// progress or a result waits to be taken, until the queue is full.
// Mode 3 and loads to a slot beyond the table are dropped. Tables must be
// loaded in ascending order, and counts written only while no item is in
// flight; a count of zero acts as one and a count beyond the table depth as
// the depth. The table memories are not cleared at reset: a query that
// reaches an entry never written returns an unspecified cost.
// ----------------------------------------------------------------------------
module two_table_nearest_visit_cost #(
  parameter int TABLE_DEPTH = 1024,
  parameter int POS_BITS    = 40
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [ttnv_pkg::MODE_BITS-1:0]    in_mode,
  input  logic [ttnv_pkg::SLOT_BITS-1:0]    in_slot,
  input  logic [POS_BITS-1:0]               in_position,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [POS_BITS:0]                 out_cost,
  input  logic                              cfg_we,
  input  logic [ttnv_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [ttnv_pkg::REG_BITS-1:0]     cfg_wdata
);
  import ttnv_pkg::*;

  // Packed queue item: kind, slot and position.
  localparam int QW = MODE_BITS + SLOT_BITS + POS_BITS;

  logic [REG_BITS-1:0] count_a_r;
  logic [REG_BITS-1:0] count_b_r;

  logic          push_valid, push_ready;
  logic [QW-1:0] push_data;
  logic          pop_valid, pop_ready;
  logic [QW-1:0] pop_data;

  // Table counts; both start at one entry.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_a_r <= REG_BITS'(1);
      count_b_r <= REG_BITS'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COUNT_A: count_a_r <= cfg_wdata;
        CFG_COUNT_B: count_b_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Front: registers each item and filters out those with no effect.
  ttnv_front #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .POS_BITS    (POS_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_mode     (in_mode),
    .in_slot     (in_slot),
    .in_position (in_position),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_data   (push_data)
  );

  // The queue decouples the front from the long-running back end.
  ttnv_queue #(
    .W (QW)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Back end: table writes, the two searches and the cost combine.
  ttnv_back #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .POS_BITS    (POS_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .count_a   (count_a_r),
    .count_b   (count_b_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_cost  (out_cost)
  );

endmodule

@@ tb/sv/two_table_nearest_visit_cost_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_table_nearest_visit_cost_test: self-checking bench for the visit cost block
// Loads sorted (and sometimes scrambled) position tables, fires queries at them
// and compares every returned cost with a cycle-free model kept in the bench.
// ----------------------------------------------------------------------------
// How the bench works:
// An initial block plans the run phase by phase. Each phase waits until the
// block is idle, writes both table counts, refills tables where needed or
// at random. It then queues a random mix of queries, loads and ignored items.
// A clocked driver presents the queued items one at a time and updates the
// bench's own copy of the tables at the moment an item is accepted. For each
// accepted query it computes the expected cost and appends it to a list.
// A clocked monitor pops that list for every cost the block hands over.
// Both sides idle in random bursts, and one phase holds the output off long
// enough that the block backs up and stalls its input.
// ----------------------------------------------------------------------------
module two_table_nearest_visit_cost_test;
  import ttnv_pkg::*;

  localparam int DEPTH = 1024;
  localparam int PBITS = 40;
  localparam logic [PBITS-1:0] POS_MAX = '1;
  localparam logic [MODE_BITS-1:0] MODE_UNUSED = 2'd3;

  // Run length and pacing.
  localparam int RANDOM_ITEMS = 1450;
  localparam int CALM_TAIL = 150;
  localparam int LONG_HOLD = 600;
  localparam int SETTLE_CYCLES = 60;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [MODE_BITS-1:0] mode;
    logic [SLOT_BITS-1:0] slot;
    logic [PBITS-1:0]     position;
  } visit_item_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [MODE_BITS-1:0]    in_mode = '0;
  logic [SLOT_BITS-1:0]    in_slot = '0;
  logic [PBITS-1:0]        in_position = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [PBITS:0]          out_cost;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [REG_BITS-1:0]     cfg_wdata = '0;

  // Bench copy of the block state, updated as items are accepted.
  logic [PBITS-1:0] mirror_a [DEPTH];
  logic [PBITS-1:0] mirror_b [DEPTH];
  logic [REG_BITS-1:0] count_a_mirror = 11'd1;
  logic [REG_BITS-1:0] count_b_mirror = 11'd1;

  // Table contents as planned by the stimulus, ahead of the block.
  logic [PBITS-1:0] plan_a [DEPTH];
  logic [PBITS-1:0] plan_b [DEPTH];
  int len_a = 0;
  int len_b = 0;

  visit_item_t      queued_items [$];
  logic [PBITS:0]   pending_costs [$];
  visit_item_t      next_item;
  logic [PBITS:0]   want_cost;

  bit idle_on = 1'b1;
  int gap_left = 0;
  int burst_left = 0;
  int hold_left = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int random_items = 0;
  int mismatches = 0;
  int cycle_count = 0;
  int phase;

  two_table_nearest_visit_cost u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_mode    (in_mode),
    .in_slot    (in_slot),
    .in_position(in_position),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_cost   (out_cost),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Model of the search and the cost.
  // ---------------------------------------------------------------------------

  // A count of zero behaves as one entry, anything past the depth as full.
  function automatic int clamp_count(logic [REG_BITS-1:0] c);
    if (c == 0) return 1;
    if (c > DEPTH) return DEPTH;
    return int'(c);
  endfunction

  function automatic logic [PBITS:0] span(logic [PBITS-1:0] p, logic [PBITS-1:0] q);
    return (p >= q) ? {1'b0, p - q} : {1'b0, q - p};
  endfunction

  // Binary search for the first entry at or above x; returns that entry and
  // the one just below it, whichever of the two exist.
  function automatic void neighbors(input bit from_b, input logic [PBITS-1:0] x,
                                    output logic [PBITS-1:0] c0,
                                    output logic [PBITS-1:0] c1, output int found);
    int n;
    int lo;
    int hi;
    int mid;
    logic [PBITS-1:0] probe;
    n = clamp_count(from_b ? count_b_mirror : count_a_mirror);
    lo = 0;
    hi = n;
    found = 0;
    c0 = '0;
    c1 = '0;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      probe = from_b ? mirror_b[mid] : mirror_a[mid];
      if (probe < x) lo = mid + 1;
      else hi = mid;
    end
    if (lo < n) begin
      c0 = from_b ? mirror_b[lo] : mirror_a[lo];
      found = 1;
    end
    if (lo > 0) begin
      if (found == 0) c0 = from_b ? mirror_b[lo - 1] : mirror_a[lo - 1];
      else c1 = from_b ? mirror_b[lo - 1] : mirror_a[lo - 1];
      found++;
    end
  endfunction

  // Shortest trip from x that touches one A candidate and one B candidate.
  function automatic logic [PBITS:0] nearest_visit_cost(logic [PBITS-1:0] x);
    logic [PBITS-1:0] ca [2];
    logic [PBITS-1:0] cb [2];
    int na;
    int nb;
    logic [PBITS:0] best;
    logic [PBITS:0] da;
    logic [PBITS:0] db;
    logic [PBITS:0] trip;
    neighbors(1'b0, x, ca[0], ca[1], na);
    neighbors(1'b1, x, cb[0], cb[1], nb);
    best = '1;
    for (int i = 0; i < na; i++) begin
      for (int j = 0; j < nb; j++) begin
        da = span(x, ca[i]);
        db = span(x, cb[j]);
        trip = ((da < db) ? da : db) + span(ca[i], cb[j]);
        if (trip < best) best = trip;
      end
    end
    return best;
  endfunction

  // Applies an accepted item: loads to the bench tables, queries to the cost list.
  function automatic void track_item(logic [MODE_BITS-1:0] mode, logic [SLOT_BITS-1:0] slot,
                                     logic [PBITS-1:0] pos);
    case (mode)
      OP_LOAD_A: mirror_a[slot] = pos;
      OP_LOAD_B: mirror_b[slot] = pos;
      OP_QUERY:  pending_costs = {pending_costs, nearest_visit_cost(pos)};
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  function automatic logic [PBITS-1:0] rand40();
    return {8'($urandom()), $urandom()};
  endfunction

  function automatic logic [PBITS-1:0] sat_add(logic [PBITS-1:0] v, logic [63:0] d);
    logic [63:0] s;
    s = 64'(v) + d;
    if (s > 64'(POS_MAX)) return POS_MAX;
    return s[PBITS-1:0];
  endfunction

  // Moves a position by a few units either way without wrapping.
  function automatic logic [PBITS-1:0] nudge(logic [PBITS-1:0] v);
    int d;
    d = $urandom_range(3, 0);
    if ($urandom_range(1, 0) == 0) return (v >= PBITS'(d)) ? v - PBITS'(d) : '0;
    return sat_add(v, 64'(d));
  endfunction

  function automatic int pick_count();
    int r;
    r = $urandom_range(99, 0);
    if (r < 5) return 0;
    if (r < 55) return $urandom_range(8, 1);
    if (r < 85) return $urandom_range(40, 9);
    return $urandom_range(128, 41);
  endfunction

  // Query positions cluster around table entries, where the search has to
  // pick between neighbors, with some extremes and free values mixed in.
  function automatic logic [PBITS-1:0] pick_query_pos(int na, int nb);
    logic [PBITS-1:0] a;
    logic [PBITS-1:0] b;
    a = plan_a[$urandom_range(na - 1, 0)];
    b = plan_b[$urandom_range(nb - 1, 0)];
    case ($urandom_range(9, 0))
      0: return '0;
      1: return POS_MAX;
      2, 3: return nudge(a);
      4, 5: return nudge(b);
      6: return ($urandom_range(1, 0) == 0) ? a : b;
      7: return PBITS'(({1'b0, a} + {1'b0, b}) >> 1);
      default: return rand40() >> $urandom_range(PBITS - 1, 0);
    endcase
  endfunction

  function automatic void queue_item(logic [MODE_BITS-1:0] mode, int slot,
                                     logic [PBITS-1:0] pos);
    visit_item_t it;
    it.mode = mode;
    it.slot = SLOT_BITS'(slot);
    it.position = pos;
    queued_items = {queued_items, it};
    if (mode == OP_LOAD_A) plan_a[slot] = pos;
    if (mode == OP_LOAD_B) plan_b[slot] = pos;
  endfunction

  // Writes entries 0..n-1 of one table in ascending order. The step size
  // sets how spread out the values are; a zero step gives runs of equal values.
  function automatic void fill_table(bit is_b, int n);
    logic [63:0] step;
    logic [PBITS-1:0] v;
    case ($urandom_range(4, 0))
      0: step = 64'd0;
      1: step = 64'd3;
      2: step = 64'd1 << 12;
      3: step = 64'd1 << 28;
      default: step = 64'd1 << 36;
    endcase
    v = ($urandom_range(1, 0) == 0) ? '0 : rand40() >> $urandom_range(PBITS - 1, 0);
    for (int i = 0; i < n; i++) begin
      if (i > 0) v = sat_add(v, {$urandom(), $urandom()} % (step + 64'd1));
      queue_item(is_b ? OP_LOAD_B : OP_LOAD_A, i, v);
      random_items++;
    end
  endfunction

  // Waits until every queued item went in and every expected cost came out,
  // then lets trailing loads drain from the block's internal queue.
  task automatic wait_idle();
    do @(negedge clk);
    while (queued_items.size() != 0 || in_valid || pending_costs.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(logic [CFG_IDX_BITS-1:0] idx, int value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= REG_BITS'(value);
    if (idx == CFG_COUNT_A) count_a_mirror = REG_BITS'(value);
    else count_b_mirror = REG_BITS'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Hand-picked items: extreme positions, single-entry tables, a zero count,
  // duplicate entries, an ignored mode, a query with a stray slot and a
  // table loaded out of order.
  task automatic directed_items();
    queue_item(OP_LOAD_A, 0, '0);
    queue_item(OP_LOAD_B, 0, POS_MAX);
    queue_item(OP_QUERY, 0, '0);
    queue_item(OP_QUERY, 0, POS_MAX);
    queue_item(OP_QUERY, 0, POS_MAX >> 1);
    queue_item(MODE_UNUSED, DEPTH - 1, POS_MAX);
    queue_item(OP_LOAD_A, DEPTH - 1, POS_MAX);
    queue_item(OP_LOAD_B, DEPTH - 1, '0);
    queue_item(OP_QUERY, DEPTH - 1, 40'd12345);
    wait_idle();
    write_count(CFG_COUNT_A, 0);
    write_count(CFG_COUNT_B, 3);
    queue_item(OP_LOAD_B, 0, 40'd100);
    queue_item(OP_LOAD_B, 1, 40'd100);
    queue_item(OP_LOAD_B, 2, POS_MAX);
    queue_item(OP_QUERY, 0, 40'd100);
    queue_item(OP_QUERY, 0, 40'd99);
    queue_item(OP_QUERY, 0, 40'd101);
    queue_item(OP_QUERY, 0, '0);
    queue_item(OP_QUERY, 0, POS_MAX);
    wait_idle();
    write_count(CFG_COUNT_A, 4);
    write_count(CFG_COUNT_B, 1);
    queue_item(OP_LOAD_A, 0, 40'd500);
    queue_item(OP_LOAD_A, 1, 40'd10);
    queue_item(OP_LOAD_A, 2, 40'd900);
    queue_item(OP_LOAD_A, 3, 40'd3);
    queue_item(OP_QUERY, 0, 40'd400);
    queue_item(OP_QUERY, 0, 40'd5);
    len_a = 4;
    len_b = 3;
  endtask

  // One random phase: new counts, tables refilled where the count needs it
  // or at random, then a mix dominated by queries. A full table is kept once
  // it is loaded.
  task automatic run_phase(int cfg_a, int cfg_b, int n_items, bit long_hold);
    int na;
    int nb;
    int lim;
    int r;
    bit is_b;
    wait_idle();
    write_count(CFG_COUNT_A, cfg_a);
    write_count(CFG_COUNT_B, cfg_b);
    if (long_hold) hold_req <= hold_req + 1;
    na = clamp_count(REG_BITS'(cfg_a));
    nb = clamp_count(REG_BITS'(cfg_b));
    if (na > len_a || (na < DEPTH && $urandom_range(9, 0) < 7)) begin
      fill_table(1'b0, na);
      if (na > len_a) len_a = na;
    end
    if (nb > len_b || (nb < DEPTH && $urandom_range(9, 0) < 7)) begin
      fill_table(1'b1, nb);
      if (nb > len_b) len_b = nb;
    end
    idle_on <= (random_items < RANDOM_ITEMS - CALM_TAIL) && ($urandom_range(3, 0) != 0);
    for (int k = 0; k < n_items; k++) begin
      r = $urandom_range(99, 0);
      if (r < 5) begin
        queue_item(MODE_UNUSED, $urandom_range(DEPTH - 1, 0), rand40());
      end else begin
        is_b = 1'($urandom_range(1, 0));
        lim = is_b ? nb : na;
        // Loads past the counted range are never searched in this phase.
        if (r < 13 && lim < DEPTH) begin
          queue_item(is_b ? OP_LOAD_B : OP_LOAD_A, $urandom_range(DEPTH - 1, lim), rand40());
        // Overwriting a counted entry leaves the table out of order.
        end else if (r >= 13 && r < 16) begin
          queue_item(is_b ? OP_LOAD_B : OP_LOAD_A, $urandom_range(lim - 1, 0), rand40());
        end else begin
          queue_item(OP_QUERY, $urandom_range(DEPTH - 1, 0), pick_query_pos(na, nb));
        end
        random_items++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: presents queued items and feeds accepted ones to the model.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) track_item(in_mode, in_slot, in_position);
      if (in_valid && in_stall) begin
        // The item waits; its payload stays as it is.
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (queued_items.size() != 0 && idle_on && $urandom_range(7, 0) == 0) begin
        gap_left <= $urandom_range(16, 0);
        in_valid <= 1'b0;
      end else if (queued_items.size() != 0) begin
        next_item = queued_items.pop_front();
        in_mode <= next_item.mode;
        in_slot <= next_item.slot;
        in_position <= next_item.position;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each handed-over cost and paces the output stall.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      burst_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_costs.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("cost %0d arrived with no query pending", out_cost);
        end else begin
          want_cost = pending_costs.pop_front();
          if (out_cost !== want_cost) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("cost mismatch: expected %0d, got %0d", want_cost, out_cost);
          end
        end
      end
      // A long hold makes the block back up until its input stalls.
      if (hold_seen != hold_req) begin
        hold_seen <= hold_req;
        hold_left <= LONG_HOLD;
        out_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (burst_left > 0) begin
        burst_left <= burst_left - 1;
        out_stall <= 1'b1;
      end else if (idle_on && $urandom_range(9, 0) == 0) begin
        burst_left <= $urandom_range(16, 0);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog against a hung block.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("two_table_nearest_visit_cost_test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Run plan. Phase 2 carries the long output hold, phase 3 the largest count
  // on table A, which loads it in full, and phase 4 a count at or beyond the
  // depth on that full table beside a zero count on table B.
  // ---------------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    directed_items();
    for (phase = 0; random_items < RANDOM_ITEMS; phase++) begin
      case (phase)
        2: run_phase(pick_count(), pick_count(), 80, 1'b1);
        3: run_phase(2047, pick_count(), 30, 1'b0);
        4: run_phase($urandom_range(2046, DEPTH), 0, 30, 1'b0);
        default: run_phase(pick_count(), pick_count(), $urandom_range(40, 4), 1'b0);
      endcase
    end
    wait_idle();
    if (mismatches == 0 && pending_costs.size() == 0) begin
      $display("two_table_nearest_visit_cost_test passed");
    end else begin
      $display("two_table_nearest_visit_cost_test failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/ttnv_pkg.sv
src/ttnv_front.sv
src/ttnv_queue.sv
src/ttnv_search.sv
src/ttnv_back.sv
src/two_table_nearest_visit_cost.sv
tb/sv/two_table_nearest_visit_cost_test.sv
